/* rtl/assert_macros.svh */
// assertion macros shared by the base64 decoder rtl
// no dependencies; taken in by the files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

/* rtl/b64d_pkg.sv */
// types, constants and the character classifier of the base64 decoder
// no dependencies; used by the front end, queue, back end and top
package b64d_pkg;

	// character codes
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_USCORE  = 8'h5F;
	localparam logic [7:0] CH_PAD     = 8'h3D;

	// sextet offsets of the alphabet ranges
	localparam logic [5:0] SEXT_LOWER = 6'd26;
	localparam logic [5:0] SEXT_DIGIT = 6'd52;
	localparam logic [5:0] SEXT_62    = 6'd62;
	localparam logic [5:0] SEXT_63    = 6'd63;

	// alphabet select
	localparam logic ALPHA_STD = 1'b0;
	localparam logic ALPHA_URL = 1'b1;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_INVALID   = 3'd1,
		ST_PAD       = 3'd2,
		ST_LENGTH    = 3'd3,
		ST_AFTER_PAD = 3'd4
	} status_t;

	// classified character
	typedef struct packed {
		logic [5:0] value;
		logic       pad;
		logic       bad;
	} sym_t;

	// one queued item
	typedef struct packed {
		sym_t sym;
		logic last;
		logic url;
	} entry_t;

	// map a raw byte to its sextet, or flag it as padding or invalid
	function automatic sym_t classify(input logic [7:0] ch, input logic url);
		sym_t s;
		s.value = '0;
		s.pad   = 1'b0;
		s.bad   = 1'b0;
		if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
			s.value = 6'(ch - CH_UPPER_A);
		end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
			s.value = 6'(ch - CH_LOWER_A) + SEXT_LOWER;
		end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
			s.value = 6'(ch - CH_DIGIT_0) + SEXT_DIGIT;
		end else if (url == ALPHA_URL && ch == CH_MINUS) begin
			s.value = SEXT_62;
		end else if (url == ALPHA_URL && ch == CH_USCORE) begin
			s.value = SEXT_63;
		end else if (url == ALPHA_STD && ch == CH_PLUS) begin
			s.value = SEXT_62;
		end else if (url == ALPHA_STD && ch == CH_SLASH) begin
			s.value = SEXT_63;
		end else if (url == ALPHA_STD && ch == CH_PAD) begin
			s.pad = 1'b1;
		end else begin
			s.bad = 1'b1;
		end
		return s;
	endfunction

endpackage

/* rtl/b64d_if.sv */
// valid/ready channel interfaces of the base64 decoder
// no dependencies; character channel in, result channel out
interface b64d_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       last_char;

	modport source (output valid, output char_in, output last_char, input ready);
	modport sink (input valid, input char_in, input last_char, output ready);
endinterface

interface b64d_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_out;
	logic       byte_valid;
	logic       end_of_message;
	logic [2:0] status;

	modport source (output valid, output byte_out, output byte_valid,
		output end_of_message, output status, input ready);
	modport sink (input valid, input byte_out, input byte_valid,
		input end_of_message, input status, output ready);
endinterface

/* rtl/b64d_front.sv */
// front end: alphabet register, character classification, queue push
// depends on b64d_pkg and b64d_if
module b64d_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic            cfg_wr_data,
	b64d_char_if.sink       char_chan,
	output logic            push_valid,
	input  logic            push_ready,
	output b64d_pkg::entry_t push_data
);

	logic alpha_q;

	// alphabet select register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= b64d_pkg::ALPHA_STD;
		end else if (cfg_wr_en) begin
			alpha_q <= cfg_wr_data;
		end
	end

	// classify and hand the item to the queue
	assign push_valid      = char_chan.valid;
	assign char_chan.ready = push_ready;
	assign push_data.sym   = b64d_pkg::classify(char_chan.char_in, alpha_q);
	assign push_data.last  = char_chan.last_char;
	assign push_data.url   = alpha_q;

endmodule

/* rtl/b64d_queue.sv */
// short queue that decouples the front end from the decode back end
// depends on b64d_pkg and assert_macros.svh
`include "assert_macros.svh"

module b64d_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  b64d_pkg::entry_t push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output b64d_pkg::entry_t pop_data
);

	localparam int PTR_W = b64d_pkg::QUEUE_PTR_W;
	localparam int CNT_W = PTR_W + 1;
	localparam logic [CNT_W-1:0] DEPTH = CNT_W'(b64d_pkg::QUEUE_DEPTH);

	b64d_pkg::entry_t slot_q [b64d_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != DEPTH);
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`ASSERT_IMPLY(a_count_bound, clk, arst_n, 1'b1, count_q <= DEPTH)
	`ASSERT_NEXT(a_full_holds, clk, arst_n, (count_q == DEPTH) && !pop, count_q == DEPTH)

endmodule

/* rtl/b64d_back.sv */
// back end: quartet state, byte assembly, error tracking, result register
// depends on b64d_pkg, b64d_if and assert_macros.svh
`include "assert_macros.svh"

module b64d_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  b64d_pkg::entry_t pop_data,
	b64d_result_if.source    result_chan
);

	logic [1:0]        pos_q;
	logic [5:0]        lo_q;
	logic [1:0]        pad_q;
	b64d_pkg::status_t err_q;

	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_byte_valid_q;
	logic              out_eom_q;
	b64d_pkg::status_t out_status_q;

	logic              pop;
	logic [1:0]        pos_nx;
	logic [5:0]        lo_nx;
	logic [1:0]        pad_nx;
	b64d_pkg::status_t err;
	b64d_pkg::status_t err_nx;
	b64d_pkg::status_t status;
	logic              have;
	logic [7:0]        byte_v;
	logic              emit;

	assign pop_ready = !out_valid_q || result_chan.ready;
	assign pop       = pop_valid && pop_ready;

	// decode one item against the quartet state
	always_comb begin
		pad_nx = pad_q;
		lo_nx  = lo_q;
		err    = b64d_pkg::ST_OK;
		have   = 1'b0;
		byte_v = '0;
		status = b64d_pkg::ST_OK;
		if (pop_data.sym.bad) begin
			err = b64d_pkg::ST_INVALID;
		end else if (pop_data.sym.pad) begin
			if (!pos_q[1]) begin
				err = b64d_pkg::ST_PAD;
			end else if (pos_q == 2'd2 && pad_q != 2'd0) begin
				err = b64d_pkg::ST_PAD;
			end else if (pos_q == 2'd3 && pad_q > 2'd1) begin
				err = b64d_pkg::ST_PAD;
			end else begin
				pad_nx = pad_q + 2'd1;
			end
		end else if (pad_q != 2'd0) begin
			err = b64d_pkg::ST_AFTER_PAD;
		end else begin
			case (pos_q)
				2'd0: begin
					lo_nx = pop_data.sym.value;
				end
				2'd1: begin
					byte_v = {lo_q, pop_data.sym.value[5:4]};
					lo_nx  = {2'b00, pop_data.sym.value[3:0]};
					have   = 1'b1;
				end
				2'd2: begin
					byte_v = {lo_q[3:0], pop_data.sym.value[5:2]};
					lo_nx  = {4'b0000, pop_data.sym.value[1:0]};
					have   = 1'b1;
				end
				default: begin
					byte_v = {lo_q[1:0], pop_data.sym.value};
					lo_nx  = '0;
					have   = 1'b1;
				end
			endcase
		end

		// first error of the message wins
		err_nx = (err_q == b64d_pkg::ST_OK) ? err : err_q;
		if (err_nx != b64d_pkg::ST_OK) begin
			have = 1'b0;
		end
		pos_nx = pos_q + 2'd1;

		// final status and length check on the last character
		if (pop_data.last) begin
			status = err_nx;
			if (status == b64d_pkg::ST_OK) begin
				if (pop_data.url ? (pos_nx == 2'd1) : (pos_nx != 2'd0)) begin
					status = b64d_pkg::ST_LENGTH;
				end
			end
			if (status != b64d_pkg::ST_OK) begin
				have = 1'b0;
			end
		end
		emit = pop_data.last || have;
	end

	// message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			lo_q  <= '0;
			pad_q <= '0;
			err_q <= b64d_pkg::ST_OK;
		end else if (pop) begin
			if (pop_data.last) begin
				pos_q <= '0;
				lo_q  <= '0;
				pad_q <= '0;
				err_q <= b64d_pkg::ST_OK;
			end else begin
				pos_q <= pos_nx;
				lo_q  <= lo_nx;
				pad_q <= pad_nx;
				err_q <= err_nx;
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && emit) begin
			out_valid_q <= 1'b1;
		end else if (result_chan.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_byte_q       <= have ? byte_v : 8'h00;
			out_byte_valid_q <= have;
			out_eom_q        <= pop_data.last;
			out_status_q     <= status;
		end
	end

	assign result_chan.valid          = out_valid_q;
	assign result_chan.byte_out       = out_byte_q;
	assign result_chan.byte_valid     = out_byte_valid_q;
	assign result_chan.end_of_message = out_eom_q;
	assign result_chan.status         = out_status_q;

	`ASSERT_NEXT(a_last_clears, clk, arst_n, pop && pop_data.last,
		pos_q == 2'd0 && pad_q == 2'd0 && err_q == b64d_pkg::ST_OK)
	`ASSERT_IMPLY(a_status_only_at_end, clk, arst_n,
		out_valid_q && out_status_q != b64d_pkg::ST_OK, out_eom_q && !out_byte_valid_q)

endmodule

/* rtl/base64_stream_decoder_top.sv */
// Base64 stream decoder, one character per item on char_chan, one result per
// completed byte or per flagged last character on result_chan.
// Depends on b64d_pkg, b64d_if, b64d_front, b64d_queue and b64d_back.
// Channels are valid/ready; an item moves on a clock edge with both high.
// cfg_wr_en/cfg_wr_data write the alphabet select (0 standard padded,
// 1 url-safe unpadded); write it only while no message is in flight.
// The front end classifies each character and pushes it into a four-entry
// queue; the back end pops it, updates the quartet state and loads the
// result register. Each character is held in the queue and then in the result
// register before its result is visible. One character per cycle is sustained
// while result_chan.ready stays high. When the receiver stalls the result
// register holds, the back end stops popping and the queue takes up to four
// more characters before char_chan.ready falls.
// Reset (arst_n low) clears the queue, the quartet state, the result valid
// and selects the standard alphabet; no clearing pass follows.
module base64_stream_decoder_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic          cfg_wr_data,
	b64d_char_if.sink     char_chan,
	b64d_result_if.source result_chan
);

	logic             push_valid;
	logic             push_ready;
	b64d_pkg::entry_t push_data;
	logic             pop_valid;
	logic             pop_ready;
	b64d_pkg::entry_t pop_data;

	// classification front end
	b64d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.char_chan  (char_chan),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// decoupling queue
	b64d_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	// decode back end
	b64d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.result_chan(result_chan)
	);

endmodule
